### rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// shared types and constants of the shell sort engine
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int VALUE_W     = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one classified item, as handed from the front to the back
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               store;   // room left, value goes into the store
      logic               last;    // closes the set
      logic               ovf;     // some item of this set was dropped
   } entry_type;

endpackage

### rtl/sse_ram.sv
// ----------------------------------------------------------------------------
// sse_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sse_queue.sv
// ----------------------------------------------------------------------------
// sse_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module sse_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sse_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  logic                pop,
   output sse_pkg::entry_type  pop_entry,
   output logic                pop_valid
);

   sse_pkg::entry_type                   slot_ff [sse_pkg::QUEUE_DEPTH];
   logic [sse_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sse_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sse_pkg::QUEUE_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                 do_push, do_pop;

   assign push_ready = (cnt_ff != sse_pkg::QUEUE_CNT_W'(sse_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sse_pkg::QUEUE_PTR_W'(sse_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sse_pkg::QUEUE_PTR_W'(sse_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/sse_front.sv
// ----------------------------------------------------------------------------
// sse_front
// accepts items, tracks fill level and marks each item stored or dropped
// ----------------------------------------------------------------------------
module sse_front #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [sse_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                push,
   output sse_pkg::entry_type                  push_entry,
   input  logic                                push_ready
);

   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          room;

   assign req_tready = push_ready;
   assign push       = req_tvalid & push_ready;
   assign room       = (cnt_ff < CW'(MAX_ITEMS));

   always_comb begin
      push_entry.value = req_value;
      push_entry.store = room;
      push_entry.last  = req_last;
      push_entry.ovf   = ovf_ff | ~room;
   end

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (push) begin
         if (req_last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else if (room) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

### rtl/sse_back.sv
// ----------------------------------------------------------------------------
// sse_back
// writes stored items, runs the shell sort over the ram and streams results
// ----------------------------------------------------------------------------
module sse_back #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sse_pkg::entry_type                  pop_entry,
   input  logic                                pop_valid,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [sse_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                rsp_last,
   output logic                                rsp_ovf
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int PW = CW + 1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_NEXT = 7'b0000010,
      S_HOLD = 7'b0000100,
      S_CMP  = 7'b0001000,
      S_PUT  = 7'b0010000,
      S_ORD  = 7'b0100000,
      S_OLD  = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic [CW-1:0]                 gap_ff, gap_in;
   logic [CW-1:0]                 start_ff, start_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [CW-1:0]                 slot_ff, slot_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic                          run_ovf_ff, run_ovf_in;
   logic [sse_pkg::VALUE_W-1:0]   hold_ff, hold_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sse_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [sse_pkg::VALUE_W-1:0]   wr_data;
   logic [AW-1:0]                 rd_addr;
   logic [sse_pkg::VALUE_W-1:0]   rd_data;

   logic [CW-1:0]                 n_new, gap_half, start_nx, slot_nx;
   logic [PW-1:0]                 pos_step;
   logic                          rsp_free;

   sse_ram #(
      .WIDTH (sse_pkg::VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pop        = (state_ff == S_IDLE);
   assign n_new      = n_ff + CW'(pop_entry.store);
   assign gap_half   = gap_ff >> 1;
   assign start_nx   = start_ff + 1'b1;
   assign slot_nx    = slot_ff - gap_ff;
   assign pos_step   = pos_ff + PW'(gap_ff);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_ovf    = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      gap_in       = gap_ff;
      start_in     = start_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      k_in         = k_ff;
      run_ovf_in   = run_ovf_ff;
      hold_in      = hold_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = n_ff[AW-1:0];
      wr_data      = pop_entry.value;
      rd_addr      = k_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               wr_en = pop_entry.store;
               n_in  = n_new;
               if (pop_entry.last) begin
                  run_ovf_in = pop_entry.ovf;
                  gap_in     = n_new >> 1;
                  start_in   = '0;
                  pos_in     = PW'(n_new >> 1);
                  k_in       = '0;
                  state_in   = ((n_new >> 1) == '0) ? S_ORD : S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (pos_ff < PW'(n_ff)) begin
               rd_addr  = pos_ff[AW-1:0];
               state_in = S_HOLD;
            end else if (start_nx < gap_ff) begin
               start_in = start_nx;
               pos_in   = PW'(start_nx) + PW'(gap_ff);
            end else if (gap_half == '0) begin
               k_in     = '0;
               state_in = S_ORD;
            end else begin
               gap_in   = gap_half;
               start_in = '0;
               pos_in   = PW'(gap_half);
            end
         end
         S_HOLD: begin
            // pos is at least gap, so the first compare always exists
            hold_in  = rd_data;
            slot_in  = pos_ff[CW-1:0];
            rd_addr  = pos_ff[AW-1:0] - gap_ff[AW-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff[AW-1:0];
            if ($signed(rd_data) > $signed(hold_ff)) begin
               // shift the larger element up by one gap
               wr_data = rd_data;
               slot_in = slot_nx;
               if (slot_nx >= gap_ff) begin
                  rd_addr = slot_nx[AW-1:0] - gap_ff[AW-1:0];
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               wr_data  = hold_ff;
               pos_in   = pos_step;
               state_in = S_NEXT;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff[AW-1:0];
            wr_data  = hold_ff;
            pos_in   = pos_step;
            state_in = S_NEXT;
         end
         S_ORD: begin
            state_in = S_OLD;
         end
         S_OLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data;
               rsp_ovf_in   = run_ovf_ff;
               rsp_last_in  = (k_ff == n_ff - 1'b1);
               if (k_ff == n_ff - 1'b1) begin
                  n_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff       <= gap_in;
      start_ff     <= start_in;
      pos_ff       <= pos_in;
      slot_ff      <= slot_in;
      k_ff         <= k_in;
      run_ovf_ff   <= run_ovf_in;
      hold_ff      <= hold_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

### rtl/shell_sort_engine.sv
// ----------------------------------------------------------------------------
// shell_sort_engine
// collects a set of signed 32-bit values and streams them back sorted
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one value per item; req_tlast closes the set. up to
//   MAX_ITEMS values are kept, further items of the set are dropped and every
//   result of that set then has rsp_tuser set.
//   rsp_* returns the set in ascending order, rsp_tlast on the last one.
// throughput and sequencing:
//   the front takes one item per cycle into a two-entry queue while it has
//   room; the back writes one item per cycle into the store while no sort
//   runs. the sort uses one ram read and one write per cycle: each gap
//   position is read (S_NEXT), held while the element one gap below is read
//   (S_HOLD), and larger elements shift up (S_CMP) until the held value is
//   written (S_CMP or S_PUT). each result is read (S_ORD), then registered
//   for output (S_OLD); the serial compare and shift loop sets the run time.
// reset:
//   synchronous, active high; the store is empty and no result is pending.
// stall:
//   a result waits in the output register while rsp_tready is low and the
//   back holds; the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module shell_sort_engine #(
   parameter int MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // is_last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // end_of_run
   output logic        rsp_tuser    // [0] overflowed
);

   sse_pkg::entry_type push_entry;   // classified item into the queue
   sse_pkg::entry_type pop_entry;    // head of the queue
   logic               push, push_ready;
   logic               pop, pop_valid;
   logic signed [31:0] rsp_value;

   // front: handshake, fill level, drop marking
   sse_front #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata),
      .req_last   (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // decouples item intake from the sort and output sequencer
   sse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid)
   );

   // back: store writes, shell sort passes, result streaming
   sse_back #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast),
      .rsp_ovf    (rsp_tuser)
   );

   assign rsp_tdata = rsp_value;

endmodule
